>>> rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types and constants shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  typedef enum logic [3:0] {
    PH_SIZE        = 4'd0,
    PH_EXT         = 4'd1,
    PH_SIZE_LF     = 4'd2,
    PH_DATA        = 4'd3,
    PH_DATA_CR     = 4'd4,
    PH_DATA_LF     = 4'd5,
    PH_TRL         = 4'd6,
    PH_TRL_END_LF  = 4'd7,
    PH_TRL_LINE    = 4'd8,
    PH_TRL_LINE_LF = 4'd9,
    PH_DONE        = 4'd10
  } phase_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_X_UC  = 8'h58;
  localparam logic [7:0] CH_X_LC  = 8'h78;

  localparam int unsigned EXT_CNT_W = 17;
  localparam logic [EXT_CNT_W-1:0] EXT_COUNT_MAX = 17'h1FFFF;

  localparam int unsigned MAX_EXT_W = 16;
  localparam logic [MAX_EXT_W-1:0] MAX_EXT_RESET = 16'd4096;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_MAX_EXT = 1'b0;

  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       byte_consumed;
    logic [1:0] decode_status;
    logic       buffer_end;
  } result_t;

endpackage

>>> rtl/hcbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// hcbd_cfg_regs
// APB register file holding the extension byte limit.
// ----------------------------------------------------------------------------
module hcbd_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hcbd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [hcbd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [hcbd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output logic [hcbd_pkg::MAX_EXT_W-1:0]       max_ext_o
);

  logic [hcbd_pkg::MAX_EXT_W-1:0] max_ext_q;
  logic                           sel_max_ext;
  logic                           wr_en;

  assign sel_max_ext = (paddr[2] == hcbd_pkg::REG_MAX_EXT);
  assign wr_en       = psel & penable & pwrite & pready;
  assign pready      = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ext_q <= hcbd_pkg::MAX_EXT_RESET;
    end else if (wr_en && sel_max_ext) begin
      max_ext_q <= pwdata[hcbd_pkg::MAX_EXT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_max_ext) begin
      prdata = {{(hcbd_pkg::APB_DATA_W-hcbd_pkg::MAX_EXT_W){1'b0}}, max_ext_q};
    end
  end

  assign max_ext_o = max_ext_q;

endmodule

>>> rtl/hcbd_decode_core.sv
// ----------------------------------------------------------------------------
// hcbd_decode_core
// Chunk framing state machine: size digits, extensions, payload count,
// trailer lines and the sticky error flag, one byte per accepted beat.
// ----------------------------------------------------------------------------
module hcbd_decode_core #(
  parameter int unsigned MAX_SIZE_DIGITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [7:0]                        in_byte_i,
  input  logic                              in_last_i,
  input  logic [hcbd_pkg::MAX_EXT_W-1:0]    max_ext_i,
  output hcbd_pkg::result_t                 res_o
);

  localparam int unsigned SizeW = 4 * MAX_SIZE_DIGITS;
  localparam int unsigned CntW  = $clog2(MAX_SIZE_DIGITS + 1);

  hcbd_pkg::phase_e                   phase_q, phase_d;
  logic [CntW-1:0]                    cnt_q, cnt_d;
  logic [hcbd_pkg::EXT_CNT_W-1:0]     ext_q, ext_d;
  logic [SizeW-1:0]                   size_q, size_d;
  logic [SizeW-1:0]                   rem_q, rem_d;
  logic                               err_q, err_d;

  logic                               is_hex;
  logic [3:0]                         hex_val;
  logic                               step_err;
  logic                               step_done;
  logic                               in_data;
  logic                               active;
  logic                               go;
  logic [SizeW-1:0]                   rem_next;
  logic                               is_cr;
  logic                               is_lf;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = in_byte_i[3:0];
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_cr    = (in_byte_i == hcbd_pkg::CH_CR);
  assign is_lf    = (in_byte_i == hcbd_pkg::CH_LF);
  assign rem_next = (rem_q != '0) ? rem_q - SizeW'(1) : rem_q;
  assign active   = !err_q && (phase_q != hcbd_pkg::PH_DONE);
  assign go       = accept_i && active && !step_err;

  // decode checks for the current byte
  always_comb begin
    step_err  = 1'b0;
    step_done = 1'b0;
    in_data   = 1'b0;
    unique case (phase_q)
      hcbd_pkg::PH_SIZE: begin
        step_err =
          ((cnt_q == '0) && (in_byte_i == hcbd_pkg::CH_SPACE ||
                             in_byte_i == hcbd_pkg::CH_TAB ||
                             in_byte_i == hcbd_pkg::CH_MINUS)) ||
          ((cnt_q == CntW'(1)) && (size_q == '0) &&
           (in_byte_i == hcbd_pkg::CH_X_LC || in_byte_i == hcbd_pkg::CH_X_UC)) ||
          (is_hex && (cnt_q >= CntW'(MAX_SIZE_DIGITS))) ||
          (!is_hex && ((cnt_q == '0) ||
                       (in_byte_i != hcbd_pkg::CH_SEMI && !is_cr)));
      end
      hcbd_pkg::PH_EXT: begin
        step_err = (ext_q > {1'b0, max_ext_i}) ||
                   (in_byte_i == hcbd_pkg::CH_NUL) || is_lf ||
                   (is_cr && (ext_q == '0));
      end
      hcbd_pkg::PH_SIZE_LF:     step_err = !is_lf;
      hcbd_pkg::PH_DATA:        in_data  = 1'b1;
      hcbd_pkg::PH_DATA_CR:     step_err = !is_cr;
      hcbd_pkg::PH_DATA_LF:     step_err = !is_lf;
      hcbd_pkg::PH_TRL:         step_err = is_lf;
      hcbd_pkg::PH_TRL_END_LF: begin
        step_err  = !is_lf;
        step_done = is_lf;
      end
      hcbd_pkg::PH_TRL_LINE:    step_err = is_lf;
      hcbd_pkg::PH_TRL_LINE_LF: step_err = !is_lf;
      hcbd_pkg::PH_DONE:        step_err = 1'b0;
      default:                  step_err = 1'b1;
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (go) begin
      unique case (phase_q)
        hcbd_pkg::PH_SIZE: begin
          if (!is_hex) begin
            phase_d = is_cr ? hcbd_pkg::PH_SIZE_LF : hcbd_pkg::PH_EXT;
          end
        end
        hcbd_pkg::PH_EXT: begin
          if (is_cr) begin
            phase_d = hcbd_pkg::PH_SIZE_LF;
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          phase_d = (size_q == '0) ? hcbd_pkg::PH_TRL : hcbd_pkg::PH_DATA;
        end
        hcbd_pkg::PH_DATA: begin
          if (rem_next == '0) begin
            phase_d = hcbd_pkg::PH_DATA_CR;
          end
        end
        hcbd_pkg::PH_DATA_CR:    phase_d = hcbd_pkg::PH_DATA_LF;
        hcbd_pkg::PH_DATA_LF:    phase_d = hcbd_pkg::PH_SIZE;
        hcbd_pkg::PH_TRL: begin
          phase_d = is_cr ? hcbd_pkg::PH_TRL_END_LF : hcbd_pkg::PH_TRL_LINE;
        end
        hcbd_pkg::PH_TRL_END_LF: phase_d = hcbd_pkg::PH_DONE;
        hcbd_pkg::PH_TRL_LINE: begin
          if (is_cr) begin
            phase_d = hcbd_pkg::PH_TRL_LINE_LF;
          end
        end
        hcbd_pkg::PH_TRL_LINE_LF: phase_d = hcbd_pkg::PH_TRL;
        default:                  phase_d = phase_q;
      endcase
    end
  end

  // counters and size registers
  always_comb begin
    cnt_d  = cnt_q;
    ext_d  = ext_q;
    size_d = size_q;
    rem_d  = rem_q;
    err_d  = err_q | (accept_i && active && step_err);
    if (go) begin
      unique case (phase_q)
        hcbd_pkg::PH_SIZE: begin
          if (is_hex) begin
            size_d = (size_q << 4) | SizeW'(hex_val);
            cnt_d  = cnt_q + CntW'(1);
          end else if (!is_cr) begin
            ext_d = '0;
          end
        end
        hcbd_pkg::PH_EXT: begin
          if (!is_cr && (ext_q < hcbd_pkg::EXT_COUNT_MAX)) begin
            ext_d = ext_q + hcbd_pkg::EXT_CNT_W'(1);
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (size_q != '0) begin
            rem_d = size_q;
          end
        end
        hcbd_pkg::PH_DATA:    rem_d = rem_next;
        hcbd_pkg::PH_DATA_LF: begin
          size_d = '0;
          cnt_d  = '0;
          ext_d  = '0;
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  // result of this beat
  always_comb begin
    res_o.payload_valid = go && in_data;
    res_o.payload_byte  = (go && in_data) ? in_byte_i : 8'h00;
    res_o.byte_consumed = go;
    res_o.buffer_end    = in_last_i;
    if (err_q) begin
      res_o.decode_status = hcbd_pkg::ST_ERR;
    end else if (phase_q == hcbd_pkg::PH_DONE) begin
      res_o.decode_status = hcbd_pkg::ST_DONE;
    end else if (step_err) begin
      res_o.decode_status = hcbd_pkg::ST_ERR;
    end else if (step_done) begin
      res_o.decode_status = hcbd_pkg::ST_DONE;
    end else begin
      res_o.decode_status = hcbd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hcbd_pkg::PH_SIZE;
      cnt_q   <= '0;
      ext_q   <= '0;
      size_q  <= '0;
      rem_q   <= '0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ext_q   <= ext_d;
      size_q  <= size_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

endmodule

>>> rtl/hcbd_out_stage.sv
// ----------------------------------------------------------------------------
// hcbd_out_stage
// Result register on the master side; takes a new result when it is empty
// or when the held one leaves in the same cycle.
// ----------------------------------------------------------------------------
module hcbd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hcbd_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              can_load_o,
  output hcbd_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  hcbd_pkg::result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/http_chunked_body_decoder_unit.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Strict HTTP/1.1 chunked body decoder: one body byte in, one result out.
// ----------------------------------------------------------------------------
// Each beat on the slave side carries one body byte and gives exactly one
// result beat in the next cycle. A byte is taken in every cycle: the framing
// state, 4*MAX_SIZE_DIGITS-bit size and remaining-payload count all update
// in the cycle the byte is accepted, and the single result register lets
// the next byte in as long as the master side takes the held result.
// s_axis_tready drops only while a result waits and m_axis_tready is low.
// Once an error is reported every later byte reports the error again until
// reset; once the body completes every later byte reports done.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit #(
  parameter int unsigned MAX_SIZE_DIGITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave side
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // [7:0] in_byte
  input  logic                                  s_axis_tlast,
  // master side
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] payload_byte, [8] byte_consumed, [10:9] decode_status, rest zero
  output logic [hcbd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tuser,  // [0] payload_valid
  output logic                                  m_axis_tlast,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [hcbd_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [hcbd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [hcbd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  logic [hcbd_pkg::MAX_EXT_W-1:0] max_ext;
  logic                           accept;
  logic                           can_load;
  hcbd_pkg::result_t              core_res;
  hcbd_pkg::result_t              out_res;

  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && can_load;

  hcbd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_ext_o (max_ext)
  );

  hcbd_decode_core #(
    .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (s_axis_tdata),
    .in_last_i (s_axis_tlast),
    .max_ext_i (max_ext),
    .res_o     (core_res)
  );

  hcbd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (core_res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .can_load_o  (can_load),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.decode_status, out_res.byte_consumed,
                         out_res.payload_byte};
  assign m_axis_tuser = out_res.payload_valid;
  assign m_axis_tlast = out_res.buffer_end;

endmodule

>>> rtl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks for the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hcbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_beat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte produced no result beat");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[8] && (m_axis_tdata[10:9] == hcbd_pkg::ST_OK))
    else $error("payload beat not consumed with ok status");

  a_err_not_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[10:9] == hcbd_pkg::ST_ERR) |->
      !m_axis_tdata[8] && !m_axis_tuser)
    else $error("error beat marked consumed");

  a_no_byte_without_payload: assert property (@(posedge clk_i)
    disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("payload byte nonzero without payload flag");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (.*);

>>> tb/sv/http_chunked_body_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit_tb
// Self-checking bench for the strict chunked body decoder.
// ----------------------------------------------------------------------------
// A 16-digit size line opens the body from a fixed table. Many well-formed
// chunks with random sizes, digit counts, letter case, extensions and payload
// follow, split into segments with a different extension limit each. Because
// errors and completion hold until reset, every run closes the body with one
// randomly chosen ending (completion, a huge chunk or one of the framing
// errors) followed by noise bytes. An in-bench decoder predicts every result
// beat. Both stream sides stall at random, in some segments but not the last.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcbd_pkg::*;

  localparam int unsigned SIZE_DIGITS_MAX = 16;
  localparam logic [APB_ADDR_W-1:0] EXT_LIMIT_ADDR = APB_ADDR_W'(4 * REG_MAX_EXT);
  localparam int SEGMENTS = 6;
  localparam int SEGMENT_BEATS = 300;

  typedef enum int {
    END_DONE, END_HUGE, END_LEAD_BLANK, END_NOT_HEX, END_HEX_PREFIX, END_TOO_MANY_DIGITS,
    END_AFTER_DIGITS, END_SIZE_NO_LF, END_EXT_BAD, END_EXT_OVER_LIMIT, END_DATA_NO_CR,
    END_DATA_NO_LF, END_TRAILER_BAD
  } body_end_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // predicted decoder state
  phase_e               ph = PH_SIZE;
  logic [4:0]           digits = '0;
  logic [EXT_CNT_W-1:0] ext_cnt = '0;
  logic [63:0]          acc_size = '0;
  logic [63:0]          remaining = '0;
  bit                   err_latched = 1'b0;
  logic [MAX_EXT_W-1:0] ext_limit = MAX_EXT_RESET;

  result_t    awaited_results[$];
  logic [7:0] body_bytes[$];
  bit         gaps_on = 1'b0;
  int         mismatches = 0;
  int         results_checked = 0;
  int         payload_beats = 0;
  int         beats_sent = 0;
  int         chunks_sent = 0;
  int         limit_writes = 0;
  body_end_e  body_end;

  stim_row_t opening_rows [22] = '{
    '{"0", 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, ST_OK, 1'b0}},
    '{"0", 1'b1, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b1, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0}, '{"0", 1'b0, 1'b0, '0},
    '{"2", 1'b0, 1'b0, '0},
    '{CH_CR, 1'b0, 1'b0, '0},
    '{CH_LF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, ST_OK, 1'b1}},
    '{8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 1'b1, ST_OK, 1'b0}},
    '{CH_CR, 1'b1, 1'b0, '0},
    '{CH_LF, 1'b0, 1'b0, '0}
  };

  http_chunked_body_decoder_unit #(
    .MAX_SIZE_DIGITS(SIZE_DIGITS_MAX)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic result_t chunk_decode(input logic [7:0] b, input logic last);
    result_t    r;
    logic [1:0] st;
    bit         pv;
    int         hv;
    r = '0;
    pv = 1'b0;
    st = ST_OK;
    hv = -1;
    if (err_latched) begin
      st = ST_ERR;
    end else if (ph == PH_DONE) begin
      st = ST_DONE;
    end else begin
      if (b >= "0" && b <= "9") hv = b - "0";
      else if (b >= "a" && b <= "f") hv = b - "a" + 10;
      else if (b >= "A" && b <= "F") hv = b - "A" + 10;
      case (ph)
        PH_SIZE: begin
          if (digits == 0 && (b == CH_SPACE || b == CH_TAB || b == CH_MINUS)) st = ST_ERR;
          else if (digits == 1 && acc_size == 0 && (b == CH_X_LC || b == CH_X_UC)) st = ST_ERR;
          else if (hv >= 0) begin
            if (digits >= SIZE_DIGITS_MAX) begin
              st = ST_ERR;
            end else begin
              acc_size = {acc_size[59:0], 4'(hv)};
              digits++;
            end
          end else if (digits == 0) st = ST_ERR;
          else if (b == CH_SEMI) begin
            ext_cnt = '0;
            ph = PH_EXT;
          end else if (b == CH_CR) ph = PH_SIZE_LF;
          else st = ST_ERR;
        end
        PH_EXT: begin
          if (ext_cnt > ext_limit) st = ST_ERR;
          else if (b == CH_NUL || b == CH_LF) st = ST_ERR;
          else if (b == CH_CR) begin
            if (ext_cnt == 0) st = ST_ERR;
            else ph = PH_SIZE_LF;
          end else if (ext_cnt < EXT_COUNT_MAX) ext_cnt++;
        end
        PH_SIZE_LF: begin
          if (b != CH_LF) st = ST_ERR;
          else if (acc_size == 0) ph = PH_TRL;
          else begin
            remaining = acc_size;
            ph = PH_DATA;
          end
        end
        PH_DATA: begin
          pv = 1'b1;
          if (remaining != 0) remaining--;
          if (remaining == 0) ph = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (b != CH_CR) st = ST_ERR;
          else ph = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (b != CH_LF) begin
            st = ST_ERR;
          end else begin
            ph = PH_SIZE;
            acc_size = '0;
            digits = '0;
            ext_cnt = '0;
          end
        end
        PH_TRL: begin
          if (b == CH_CR) ph = PH_TRL_END_LF;
          else if (b == CH_LF) st = ST_ERR;
          else ph = PH_TRL_LINE;
        end
        PH_TRL_END_LF: begin
          if (b != CH_LF) begin
            st = ST_ERR;
          end else begin
            ph = PH_DONE;
            st = ST_DONE;
          end
        end
        PH_TRL_LINE: begin
          if (b == CH_CR) ph = PH_TRL_LINE_LF;
          else if (b == CH_LF) st = ST_ERR;
        end
        PH_TRL_LINE_LF: begin
          if (b != CH_LF) st = ST_ERR;
          else ph = PH_TRL;
        end
        default: st = ST_ERR;
      endcase
      if (st == ST_ERR) begin
        err_latched = 1'b1;
        pv = 1'b0;
      end else begin
        r.byte_consumed = 1'b1;
      end
    end
    r.payload_valid = pv;
    r.payload_byte = pv ? b : 8'h00;
    r.decode_status = st;
    r.buffer_end = last;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'("0" + nib);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10);
  endfunction

  function automatic logic [7:0] pick_text_byte(input bit allow_nul);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || (!allow_nul && b == CH_NUL));
    return b;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
  endtask

  task automatic push_one_of(input string alt);
    body_bytes.push_back(alt[$urandom_range(0, alt.len() - 1)]);
  endtask

  task automatic push_size_line(input logic [63:0] size, input int ndigits, input int ext_len);
    for (int i = ndigits - 1; i >= 0; i--) body_bytes.push_back(hex_char(size[4*i +: 4]));
    if (ext_len > 0) begin
      body_bytes.push_back(CH_SEMI);
      repeat (ext_len) body_bytes.push_back(pick_text_byte(1'b0));
    end
    body_bytes.push_back(CH_CR);
    body_bytes.push_back(CH_LF);
  endtask

  task automatic send_beat(input logic [7:0] b, input logic last, input bit typed,
                           input result_t fixed);
    result_t want;
    int      n;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk);
    while (!s_axis_tready);
    want = chunk_decode(b, last);
    awaited_results.push_back(typed ? fixed : want);
    beats_sent++;
  endtask

  task automatic send_body();
    while (body_bytes.size() > 0)
      send_beat(body_bytes.pop_front(), $urandom_range(0, 3) == 0, 1'b0, '0);
  endtask

  task automatic wait_decoder_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk);
    while (awaited_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_ext_limit(input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EXT_LIMIT_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ext_limit = value[MAX_EXT_W-1:0];
    limit_writes++;
  endtask

  task automatic send_random_chunk();
    logic [63:0] size;
    int          pick;
    int          min_digits;
    int          ndigits;
    int          ext_len;
    int          ext_cap;
    pick = $urandom_range(0, 19);
    if (pick < 16) size = 64'($urandom_range(1, 24));
    else if (pick < 19) size = 64'($urandom_range(25, 96));
    else size = 64'($urandom_range(97, 255));
    min_digits = 1;
    for (int i = 1; i < SIZE_DIGITS_MAX; i++) if (size[4*i +: 4] != 0) min_digits = i + 1;
    ndigits = $urandom_range(0, 2) != 0 ? min_digits : $urandom_range(min_digits, SIZE_DIGITS_MAX);
    ext_len = 0;
    ext_cap = ext_limit < 12 ? ext_limit : 12;
    if (ext_cap > 0 && $urandom_range(0, 2) == 0)
      ext_len = $urandom_range(0, 1) ? ext_cap : $urandom_range(1, ext_cap);
    push_size_line(size, ndigits, ext_len);
    repeat (size) body_bytes.push_back(8'($urandom_range(0, 255)));
    body_bytes.push_back(CH_CR);
    body_bytes.push_back(CH_LF);
    chunks_sent++;
    send_body();
  endtask

  task automatic send_body_end();
    int n;
    case (body_end)
      END_DONE: begin
        push_size_line(64'd0, $urandom_range(1, 3), ext_limit != 0 ? $urandom_range(0, 1) : 0);
        repeat ($urandom_range(0, 3)) begin
          n = $urandom_range(1, 8);
          repeat (n) body_bytes.push_back(pick_text_byte(1'b1));
          push_text("\015\n");
        end
        push_text("\015\n");
      end
      END_HUGE: push_size_line({$urandom, $urandom} | 64'h1000_0000_0000_0000, 16, 0);
      END_LEAD_BLANK: begin
        push_one_of(" \t-");
        push_text("1\015\n");
      end
      END_NOT_HEX: push_one_of("gGzZ;\015\n_x");
      END_HEX_PREFIX: begin
        push_text("0");
        push_one_of("xX");
        push_text("1\015\n");
      end
      END_TOO_MANY_DIGITS:
        repeat (SIZE_DIGITS_MAX + 1) body_bytes.push_back(hex_char(4'($urandom)));
      END_AFTER_DIGITS: begin
        repeat ($urandom_range(1, 3)) body_bytes.push_back(hex_char(4'($urandom)));
        push_one_of("_\ng -\t");
      end
      END_SIZE_NO_LF: begin
        push_text("1\015");
        push_one_of("\0151a ");
      end
      END_EXT_BAD: begin
        push_text("1;");
        case ($urandom_range(0, 2))
          0: body_bytes.push_back(CH_NUL);
          1: push_text("a\n");
          default: push_text("\015\n");
        endcase
      end
      END_EXT_OVER_LIMIT: begin
        push_text("1;");
        repeat (ext_limit + 2) body_bytes.push_back(pick_text_byte(1'b0));
        push_text("\015\na\015\n");
      end
      END_DATA_NO_CR: begin
        push_text("2\015\n");
        repeat (2) body_bytes.push_back(8'($urandom_range(0, 255)));
        push_one_of("a\n ");
      end
      END_DATA_NO_LF: begin
        push_text("1\015\n");
        body_bytes.push_back(8'($urandom_range(0, 255)));
        push_text("\015");
        push_one_of("\015b");
      end
      default: begin
        push_text("0\015\n");
        case ($urandom_range(0, 3))
          0: push_text("\n");
          1: push_text("\015\015");
          2: push_text("a:b\n");
          default: push_text("a:b\015\015");
        endcase
      end
    endcase
    repeat (16) body_bytes.push_back(8'($urandom_range(0, 255)));
    send_body();
  endtask

  initial begin
    wait (rst_n);
    forever begin
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[10:9], m_axis_tlast};
      results_checked++;
      if (got.payload_valid) payload_beats++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: tdata=%h tuser=%b tlast=%b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = awaited_results.pop_front();
        if (got.payload_valid !== want.payload_valid || got.payload_byte !== want.payload_byte ||
            got.byte_consumed !== want.byte_consumed ||
            got.decode_status !== want.decode_status || got.buffer_end !== want.buffer_end ||
            m_axis_tdata[OUT_TDATA_W-1:11] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: want pv=%0d byte=%h cons=%0d st=%0d end=%0d, got pv=%0d byte=%h cons=%0d st=%0d end=%0d pad=%h",
                     results_checked, want.payload_valid, want.payload_byte, want.byte_consumed,
                     want.decode_status, want.buffer_end, got.payload_valid, got.payload_byte,
                     got.byte_consumed, got.decode_status, got.buffer_end,
                     m_axis_tdata[OUT_TDATA_W-1:11]);
        end
      end
    end
  end

  initial begin
    logic [APB_DATA_W-1:0] limit_plan [SEGMENTS];
    int                    seg_end;
    limit_plan = '{32'd65535, 32'd0, 32'd1, 32'd4096, $urandom_range(2, 12), $urandom};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_rows[i])
      send_beat(opening_rows[i].data, opening_rows[i].last, opening_rows[i].typed,
                opening_rows[i].want);
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_decoder_idle();
      write_ext_limit(limit_plan[seg]);
      gaps_on = seg != SEGMENTS - 1 && $urandom_range(0, 3) != 0;
      seg_end = beats_sent + SEGMENT_BEATS;
      while (beats_sent < seg_end) send_random_chunk();
    end
    body_end = body_end_e'($urandom_range(END_DONE, END_TRAILER_BAD));
    wait_decoder_idle();
    if (body_end == END_EXT_OVER_LIMIT) write_ext_limit($urandom_range(0, 6));
    send_body_end();
    wait_decoder_idle();
    repeat (8) @(posedge clk);
    $display("sent %0d body beats in %0d random chunks, %0d payload beats, %0d limit writes",
             beats_sent, chunks_sent, payload_beats, limit_writes);
    $display("body closed by %s, %0d result beats checked", body_end.name(), results_checked);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/hcbd_pkg.sv
rtl/hcbd_cfg_regs.sv
rtl/hcbd_decode_core.sv
rtl/hcbd_out_stage.sv
rtl/http_chunked_body_decoder_unit.sv
rtl/hcbd_checker.sv
tb/sv/http_chunked_body_decoder_unit_tb.sv
